// ===== rtl/core/http_request_head_parser_top_assert.svh =====
// Assertion macros for the HTTP request head parser.
// Used by http_request_head_parser_top; depends on nothing else.
`ifndef HTTP_REQUEST_HEAD_PARSER_TOP_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HRHP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrhp: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HRHP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrhp: next-cycle check failed");

`endif

// ===== rtl/core/hrhp_pkg.sv =====
// Shared types and constants for the HTTP request head parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package hrhp_pkg;

   typedef enum logic [2:0] {
      KIND_DROP    = 3'd0,
      KIND_METHOD  = 3'd1,
      KIND_TARGET  = 3'd2,
      KIND_VERSION = 3'd3,
      KIND_NAME    = 3'd4,
      KIND_VALUE   = 3'd5
   } hrhp_kind_type;

   typedef enum logic [2:0] {
      STATUS_PENDING     = 3'd0,
      STATUS_ACCEPTED    = 3'd1,
      STATUS_WORD_COUNT  = 3'd2,
      STATUS_BAD_METHOD  = 3'd3,
      STATUS_BAD_VERSION = 3'd4,
      STATUS_NO_LINE     = 3'd5
   } hrhp_status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_request;
   } hrhp_req_type;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [2:0] byte_kind;
      logic       line_commit;
      logic       missing_colon;
      logic [1:0] method_code;
      logic [2:0] request_status;
      logic       request_done;
      logic       tail_dropped;
   } hrhp_rsp_type;

   typedef struct packed {
      logic            cr_seen;
      logic            lf_seen;
      logic            line_has_bytes;
      logic            first_line_done;
      hrhp_status_type verdict;
      logic [2:0]      word_count;
      logic            inside_word;
      logic [3:0]      method_candidates;
      logic [3:0]      char_position;
      logic            version_mismatch;
      logic [1:0]      chosen_method;
      logic            colon_seen;
   } hrhp_state_type;

   // Per-character compare results for the method and version words.
   typedef struct packed {
      logic [3:0] method_keep;
      logic       version_ok;
   } hrhp_match_type;

   localparam hrhp_state_type STATE_RESET = '{
      cr_seen:           1'b0,
      lf_seen:           1'b0,
      line_has_bytes:    1'b0,
      first_line_done:   1'b0,
      verdict:           STATUS_PENDING,
      word_count:        3'd0,
      inside_word:       1'b0,
      method_candidates: 4'hF,
      char_position:     4'd0,
      version_mismatch:  1'b0,
      chosen_method:     2'd0,
      colon_seen:        1'b0
   };

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   localparam logic [2:0] WORD_METHOD  = 3'd1;
   localparam logic [2:0] WORD_TARGET  = 3'd2;
   localparam logic [2:0] WORD_VERSION = 3'd3;
   localparam logic [2:0] WORD_MAX     = 3'd7;
   localparam logic [3:0] POS_MAX      = 4'd15;
   localparam logic [3:0] VERSION_LEN  = 4'd8;

   localparam logic [1:0] METHOD_OPTIONS = 2'd0;
   localparam int         METHOD_COUNT   = 4;

   localparam logic [7:0] METHOD_TEXT [METHOD_COUNT][8] = '{
      '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{4'd7, 4'd3, 4'd4, 4'd4};

   localparam logic [7:0] VERSION_TEXT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

endpackage

`default_nettype wire

// ===== rtl/core/hrhp_char_match.sv =====
// Character compare for the request line: method candidates and version text.
// Depends on hrhp_pkg.
`default_nettype none

module hrhp_char_match (
   input  wire logic [7:0]              data_byte,
   input  wire logic [3:0]              position,
   output hrhp_pkg::hrhp_match_type     match
);
   import hrhp_pkg::*;

   logic [7:0] upper_byte;

   // Only a-z fold to upper case, and only for the version compare; the method compare is case sensitive.
   assign upper_byte = (data_byte >= CHAR_LOW_A && data_byte <= CHAR_LOW_Z) ?
                       data_byte - CASE_DELTA : data_byte;

   always_comb begin
      for (int m = 0; m < METHOD_COUNT; m++) begin
         match.method_keep[m] = (position < METHOD_LEN[m]) &&
                                (METHOD_TEXT[m][position[2:0]] == data_byte);
      end
      match.version_ok = !position[3] && (VERSION_TEXT[position[2:0]] == upper_byte);
   end

endmodule

`default_nettype wire

// ===== rtl/core/hrhp_step.sv =====
// Parse state and per-byte tagging logic of the request head parser.
// Depends on hrhp_pkg and hrhp_char_match.
`default_nettype none

module hrhp_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire hrhp_pkg::hrhp_req_type item,
   output hrhp_pkg::hrhp_rsp_type     result
);
   import hrhp_pkg::*;

   hrhp_state_type  state_ff;
   hrhp_state_type  state_in;
   hrhp_match_type  match;
   logic [3:0]      match_position;

   // A byte that opens a word is compared at position zero.
   assign match_position = state_ff.inside_word ? state_ff.char_position : 4'd0;

   hrhp_char_match u_char_match (
      .data_byte (item.data_byte),
      .position  (match_position),
      .match     (match)
   );

   hrhp_state_type  st;
   hrhp_kind_type   kind;
   hrhp_status_type status;
   logic            commit;
   logic            end_now;
   logic            tail;
   logic            no_colon;
   logic [3:0]      len_keep;
   logic [3:0]      cand;
   logic [1:0]      mcode;

   always_comb begin
      st       = state_ff;
      kind     = KIND_DROP;
      no_colon = 1'b0;
      tail     = 1'b0;
      len_keep = 4'd0;
      cand     = 4'd0;

      if (item.data_byte == CHAR_CR) begin
         st.cr_seen = 1'b1;
      end else if (item.data_byte == CHAR_LF) begin
         if (state_ff.cr_seen) begin
            st.lf_seen = 1'b1;
         end
      end else begin
         st.line_has_bytes = 1'b1;
         if (!state_ff.first_line_done) begin
            if (item.data_byte != CHAR_SPACE) begin
               if (!state_ff.inside_word) begin
                  st.inside_word   = 1'b1;
                  st.char_position = 4'd0;
                  if (state_ff.word_count != WORD_MAX) begin
                     st.word_count = state_ff.word_count + 3'd1;
                  end
               end
               if (st.word_count == WORD_METHOD) begin
                  kind                 = KIND_METHOD;
                  st.method_candidates = st.method_candidates & match.method_keep;
               end else if (st.word_count == WORD_TARGET) begin
                  kind = KIND_TARGET;
               end else if (st.word_count == WORD_VERSION) begin
                  kind = KIND_VERSION;
                  if (!match.version_ok) begin
                     st.version_mismatch = 1'b1;
                  end
               end
               if (st.char_position != POS_MAX) begin
                  st.char_position = st.char_position + 4'd1;
               end
            end
         end else begin
            if (item.data_byte == CHAR_COLON && !state_ff.colon_seen) begin
               st.colon_seen = 1'b1;
            end else begin
               kind = state_ff.colon_seen ? KIND_VALUE : KIND_NAME;
            end
         end
      end

      commit = st.cr_seen && st.lf_seen && st.line_has_bytes;

      // A word ends on a space or when the request line commits; both cases share
      // one check, so at most one word end happens per byte.
      end_now = !state_ff.first_line_done && st.inside_word &&
                (item.data_byte == CHAR_SPACE || commit);

      if (end_now) begin
         if (st.word_count == WORD_METHOD) begin
            for (int m = 0; m < METHOD_COUNT; m++) begin
               len_keep[m] = (METHOD_LEN[m] == st.char_position);
            end
            cand                 = st.method_candidates & len_keep;
            st.method_candidates = cand;
            for (int m = METHOD_COUNT - 1; m >= 0; m--) begin
               if (cand[m]) begin
                  st.chosen_method = 2'(m);
               end
            end
         end else if (st.word_count == WORD_VERSION) begin
            if (st.char_position != VERSION_LEN) begin
               st.version_mismatch = 1'b1;
            end
         end
         st.inside_word = 1'b0;
      end

      if (commit) begin
         if (!state_ff.first_line_done) begin
            if (st.word_count != WORD_VERSION) begin
               st.verdict = STATUS_WORD_COUNT;
            end else if (st.method_candidates == 4'd0) begin
               st.verdict = STATUS_BAD_METHOD;
            end else if (st.version_mismatch) begin
               st.verdict = STATUS_BAD_VERSION;
            end else begin
               st.verdict = STATUS_ACCEPTED;
            end
            st.first_line_done = 1'b1;
         end else begin
            no_colon = !st.colon_seen;
         end
         st.cr_seen        = 1'b0;
         st.lf_seen        = 1'b0;
         st.line_has_bytes = 1'b0;
         st.colon_seen     = 1'b0;
      end

      status = st.verdict;
      if (item.end_of_request) begin
         tail = st.line_has_bytes;
         if (status == STATUS_PENDING) begin
            status = STATUS_NO_LINE;
         end
      end
      mcode = (st.verdict == STATUS_ACCEPTED) ? st.chosen_method : METHOD_OPTIONS;

      result.echo_byte      = item.data_byte;
      result.byte_kind      = kind;
      result.line_commit    = commit;
      result.missing_colon  = no_colon;
      result.method_code    = mcode;
      result.request_status = status;
      result.request_done   = item.end_of_request;
      result.tail_dropped   = tail;

      // The end of a request returns the parser to its reset state.
      state_in = item.end_of_request ? STATE_RESET : st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/http_request_head_parser_top.sv =====
// A captured request byte moves from the input register into the result register when
// the latter is free or drained. Throughput: one request byte per cycle while rsp_ready
// stays high; the parse state updates once per byte, as the byte advances.
// Reset (synchronous, active high) empties both registers and returns the parse
// state to the start of a request. Depends on hrhp_pkg, hrhp_step and the assert header.
`default_nettype none

`include "http_request_head_parser_top_assert.svh"

module http_request_head_parser_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire hrhp_pkg::hrhp_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output hrhp_pkg::hrhp_rsp_type      rsp_data
);
   import hrhp_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   hrhp_req_type s1_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   hrhp_rsp_type out_item_ff;
   hrhp_rsp_type step_result;
   logic         advance;
   logic         accept;

   // The captured request moves on whenever the result register is free or
   // being drained in the same cycle.
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   hrhp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   `HRHP_ASSERT_IMP(a_done_is_final, clock, reset, rsp_valid && rsp_data.request_done, rsp_data.request_status != STATUS_PENDING)
   `HRHP_ASSERT_IMP(a_tail_only_at_end, clock, reset, rsp_valid && rsp_data.tail_dropped, rsp_data.request_done)
   `HRHP_ASSERT_IMP(a_code_needs_accept, clock, reset, rsp_valid && rsp_data.method_code != METHOD_OPTIONS, rsp_data.request_status == STATUS_ACCEPTED)
   `HRHP_ASSERT_IMP(a_colon_flag_at_commit, clock, reset, rsp_valid && rsp_data.missing_colon, rsp_data.line_commit)
   `HRHP_ASSERT_NXT(a_stalled_stage_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

`default_nettype wire

// ===== test/tb_http_request_head_parser_top.sv =====
// Self-checking testbench for http_request_head_parser_top: byte streams of HTTP request
// heads go in, every tagged result is checked against a behavioral parser kept here.
// Depends on hrhp_pkg and the RTL of the block only.
module tb_http_request_head_parser_top;
   import hrhp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 400;
   localparam int PHASE_BYTES = 430;
   localparam logic [1:0] METHOD_NONE = 2'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hrhp_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hrhp_rsp_type rsp_data;

   // Request bytes waiting to be driven, and the tagged bytes the parser should return.
   hrhp_req_type request_bytes[$];
   hrhp_rsp_type awaited_tags[$];
   logic [7:0] draft[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_armed = 1'b0;
   logic hold_taken = 1'b0;
   int hold_left = 0;
   int fail_count = 0;
   int stuck_cycles = 0;
   int bytes_queued = 0;

   string method_names[4] = '{"OPTIONS", "GET", "POST", "HEAD"};
   string version_word_text = "HTTP/1.1";

   // Parse state of the expected-result model.
   logic seen_cr;
   logic seen_lf;
   logic line_nonempty;
   logic request_line_done;
   hrhp_status_type verdict_now;
   logic [2:0] word_index;
   logic in_word;
   logic [3:0] method_alive;
   logic [3:0] word_pos;
   logic version_bad;
   logic [1:0] method_pick;
   logic colon_found;

   http_request_head_parser_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic clear_parse();
      seen_cr = 1'b0;
      seen_lf = 1'b0;
      line_nonempty = 1'b0;
      request_line_done = 1'b0;
      verdict_now = STATUS_PENDING;
      word_index = 3'd0;
      in_word = 1'b0;
      method_alive = 4'hF;
      word_pos = 4'd0;
      version_bad = 1'b0;
      method_pick = 2'd0;
      colon_found = 1'b0;
   endtask

   task automatic close_word();
      if (word_index == WORD_METHOD) begin
         for (int m = 0; m < 4; m++)
            if (method_names[m].len() != word_pos) method_alive[m] = 1'b0;
         // Walk downward so the lowest surviving method wins.
         for (int m = 3; m >= 0; m--)
            if (method_alive[m]) method_pick = 2'(m);
      end else if (word_index == WORD_VERSION) begin
         if (word_pos != version_word_text.len()) version_bad = 1'b1;
      end
      in_word = 1'b0;
   endtask

   task automatic tag_byte(input hrhp_req_type rq, output hrhp_rsp_type rs);
      logic [7:0] b;
      logic [7:0] up;
      hrhp_kind_type kind;
      hrhp_status_type status;
      logic commit;
      logic no_colon;
      b = rq.data_byte;
      kind = KIND_DROP;
      commit = 1'b0;
      no_colon = 1'b0;
      if (b == CHAR_CR) begin
         seen_cr = 1'b1;
      end else if (b == CHAR_LF) begin
         if (seen_cr) seen_lf = 1'b1;
      end else begin
         line_nonempty = 1'b1;
         if (!request_line_done) begin
            if (b == CHAR_SPACE) begin
               if (in_word) close_word();
            end else begin
               if (!in_word) begin
                  in_word = 1'b1;
                  if (word_index < WORD_MAX) word_index = word_index + 3'd1;
                  word_pos = 4'd0;
               end
               if (word_index == WORD_METHOD) kind = KIND_METHOD;
               else if (word_index == WORD_TARGET) kind = KIND_TARGET;
               else if (word_index == WORD_VERSION) kind = KIND_VERSION;
               if (word_index == WORD_METHOD) begin
                  for (int m = 0; m < 4; m++)
                     if (word_pos >= method_names[m].len() || method_names[m][word_pos] != b)
                        method_alive[m] = 1'b0;
               end else if (word_index == WORD_VERSION) begin
                  up = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? b - CASE_DELTA : b;
                  if (word_pos >= version_word_text.len() || version_word_text[word_pos] != up)
                     version_bad = 1'b1;
               end
               if (word_pos < POS_MAX) word_pos = word_pos + 4'd1;
            end
         end else begin
            // Only the first colon splits name from value.
            if (b == CHAR_COLON && !colon_found) colon_found = 1'b1;
            else kind = colon_found ? KIND_VALUE : KIND_NAME;
         end
      end

      if (seen_cr && seen_lf && line_nonempty) begin
         commit = 1'b1;
         if (!request_line_done) begin
            if (in_word) close_word();
            if (word_index != WORD_VERSION) verdict_now = STATUS_WORD_COUNT;
            else if (method_alive == 4'd0) verdict_now = STATUS_BAD_METHOD;
            else if (version_bad) verdict_now = STATUS_BAD_VERSION;
            else verdict_now = STATUS_ACCEPTED;
            request_line_done = 1'b1;
         end else begin
            no_colon = !colon_found;
         end
         seen_cr = 1'b0;
         seen_lf = 1'b0;
         line_nonempty = 1'b0;
         colon_found = 1'b0;
      end

      status = verdict_now;
      if (rq.end_of_request && status == STATUS_PENDING) status = STATUS_NO_LINE;
      rs.echo_byte = b;
      rs.byte_kind = kind;
      rs.line_commit = commit;
      rs.missing_colon = no_colon;
      rs.method_code = (verdict_now == STATUS_ACCEPTED) ? method_pick : METHOD_NONE;
      rs.request_status = status;
      rs.request_done = rq.end_of_request;
      rs.tail_dropped = rq.end_of_request & line_nonempty;
      if (rq.end_of_request) clear_parse();
   endtask

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      fail_count++;
      $display("tagged byte %s: expected %0h, got %0h", field, want, got);
   endtask

   // Driver: the payload only changes once the current request has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (request_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= request_bytes.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      hrhp_rsp_type want;
      if (reset) begin
         clear_parse();
      end else begin
         if (req_valid && req_ready) begin
            tag_byte(req_data, want);
            awaited_tags = {awaited_tags, want};
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_tags.size() == 0) begin
               report("with nothing awaited, echo_byte", 0, rsp_data.echo_byte);
            end else begin
               want = awaited_tags.pop_front();
               if (rsp_data.echo_byte !== want.echo_byte)
                  report("echo_byte", want.echo_byte, rsp_data.echo_byte);
               if (rsp_data.byte_kind !== want.byte_kind)
                  report("byte_kind", want.byte_kind, rsp_data.byte_kind);
               if (rsp_data.line_commit !== want.line_commit)
                  report("line_commit", want.line_commit, rsp_data.line_commit);
               if (rsp_data.missing_colon !== want.missing_colon)
                  report("missing_colon", want.missing_colon, rsp_data.missing_colon);
               if (rsp_data.method_code !== want.method_code)
                  report("method_code", want.method_code, rsp_data.method_code);
               if (rsp_data.request_status !== want.request_status)
                  report("request_status", want.request_status, rsp_data.request_status);
               if (rsp_data.request_done !== want.request_done)
                  report("request_done", want.request_done, rsp_data.request_done);
               if (rsp_data.tail_dropped !== want.tail_dropped)
                  report("tail_dropped", want.tail_dropped, rsp_data.tail_dropped);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("http_request_head_parser_top: mismatch");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      hrhp_req_type rq;
      rq.data_byte = b;
      rq.end_of_request = last;
      request_bytes = {request_bytes, rq};
      bytes_queued++;
   endtask

   task automatic push_text(input string s, input logic last);
      foreach (s[i]) push_byte(s[i], last && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] any_text_byte();
      logic [7:0] b;
      if ($urandom_range(99) < 80) return 8'($urandom_range(33, 126));
      do b = 8'($urandom_range(255));
      while (b == CHAR_CR || b == CHAR_LF || b == CHAR_SPACE);
      return b;
   endfunction

   function automatic logic [7:0] letter();
      return 8'($urandom_range(1) ? $urandom_range(8'h41, 8'h5A) : $urandom_range(8'h61, 8'h7A));
   endfunction

   // Appends one byte to the request being composed.
   task automatic add_draft(input logic [7:0] b);
      draft = {draft, b};
   endtask

   task automatic draft_word(input string s);
      foreach (s[i]) add_draft(s[i]);
   endtask

   task automatic draft_junk(input int n);
      repeat (n) add_draft(any_text_byte());
   endtask

   // Mostly CR LF, sometimes with a stray LF or a doubled CR in front.
   task automatic draft_eol();
      int r;
      r = $urandom_range(99);
      if (r >= 92) add_draft(CHAR_CR);
      else if (r >= 85) add_draft(CHAR_LF);
      add_draft(CHAR_CR);
      add_draft(CHAR_LF);
   endtask

   task automatic queue_request();
      string word;
      int words;
      int r;
      int pick;
      r = $urandom_range(99);
      draft.delete();
      if (r < 8) begin
         // Noise: any byte values, line marks included.
         repeat ($urandom_range(1, 12)) add_draft(8'($urandom_range(255)));
      end else begin
         words = ($urandom_range(99) < 85) ? 3 : $urandom_range(1, 9);
         if ($urandom_range(9) == 0) add_draft(CHAR_SPACE);
         for (int w = 1; w <= words; w++) begin
            if (w > 1) repeat ($urandom_range(1, 2)) add_draft(CHAR_SPACE);
            if (w == 1) begin
               word = method_names[$urandom_range(3)];
               pick = $urandom_range(99);
               if (pick < 4) word[$urandom_range(word.len() - 1)] = letter();
               else if (pick < 8) word = word.substr(0, word.len() - 2);
               else if (pick < 11) word = {word, "S"};
               else if (pick < 14) begin
                  word = "";
                  repeat ($urandom_range(1, 17)) word = {word, string'(letter())};
               end
               draft_word(word);
            end else if (w == 2) begin
               draft_junk(($urandom_range(19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
            end else if (w == 3) begin
               word = version_word_text;
               foreach (word[i])
                  if (word[i] >= "A" && word[i] <= "Z" && $urandom_range(1)) word[i] = word[i] + 8'h20;
               pick = $urandom_range(99);
               if (pick < 5) word[$urandom_range(7)] = any_text_byte();
               else if (pick < 9) word = word.substr(0, $urandom_range(6));
               else if (pick < 13) repeat ($urandom_range(1, 10)) word = {word, "1"};
               draft_word(word);
            end else begin
               draft_junk($urandom_range(1, 4));
            end
         end
         if ($urandom_range(9) == 0) add_draft(CHAR_SPACE);
         draft_eol();
         repeat ($urandom_range(3)) begin
            // A blank line here leaves the marks set, so the next byte commits alone.
            if ($urandom_range(9) == 0) draft_eol();
            repeat ($urandom_range(1, 5)) add_draft(letter());
            if ($urandom_range(9) != 0) add_draft(CHAR_COLON);
            repeat ($urandom_range(6)) begin
               pick = $urandom_range(9);
               if (pick == 0) add_draft(CHAR_COLON);
               else if (pick == 1) add_draft(CHAR_SPACE);
               else add_draft(any_text_byte());
            end
            draft_eol();
         end
         r = $urandom_range(99);
         if (r < 80) draft_eol();
         else if (r < 90) draft_junk($urandom_range(1, 3));
      end
      foreach (draft[i]) push_byte(draft[i], i == draft.size() - 1);
   endtask

   // The sender holds back here until every request has produced its result.
   task automatic wait_drained();
      while (request_bytes.size() != 0 || req_valid || awaited_tags.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_byte(8'hFF, 1'b1);
      push_text("GET a hTtP/1.1", 1'b0);
      push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_byte("x", 1'b0);
      push_byte(CHAR_CR, 1'b0);
      push_byte(CHAR_LF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(CHAR_COLON, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct <= (phase == 0) ? 13 : (phase == 1) ? 76 : 0;
         recv_idle_pct <= (phase == 0) ? 76 : (phase == 1) ? 13 : 0;
         if (phase == 2) hold_armed <= 1'b1;
         @(posedge clock);
         bytes_queued = 0;
         while (bytes_queued < PHASE_BYTES) queue_request();
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("http_request_head_parser_top: match");
      end else begin
         $display("http_request_head_parser_top: mismatch");
      end
      $finish;
   end

endmodule
